// ----- design/wrp_pkg.sv -----
`timescale 1ns / 1ps

package wrp_pkg;

    // Four-character tags as they read after four little-endian byte shifts
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Minimum fmt body that is always consumed (holds the channel count)
    localparam logic [31:0] FMT_MIN_LEN = 32'd4;

    // Depth of the packet queue between parser and result expander
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SUBHDR = 3'd1,
        PH_FMT    = 3'd2,
        PH_SKIP   = 3'd3,
        PH_DATA   = 3'd4,
        PH_DONE   = 3'd5,
        PH_BAD    = 3'd6,
        PH_NODATA = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_SAMPLE = 3'd0,
        ST_DONE   = 3'd1,
        ST_BAD    = 3'd2,
        ST_NODATA = 3'd3,
        ST_TRUNC  = 3'd4
    } status_t;

    // Everything one input byte produces: up to two samples and a terminal status
    typedef struct packed {
        logic [15:0] sample;
        logic [1:0]  n_samples;
        logic        term;
        status_t     status;
    } pkt_t;

endpackage

// ----- design/wrp_front.sv -----
`timescale 1ns / 1ps

module wrp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output logic          pkt_push,
    output wrp_pkg::pkt_t pkt
);
    import wrp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] chan_reg, chan_next;
    logic [7:0]  low_reg, low_next;

    logic [31:0] count_inc;
    logic [31:0] tag_shift;
    logic [31:0] len_shift;
    logic [15:0] word;
    logic [1:0]  n_samples;
    phase_t      phase_after;
    status_t     term_status;

    assign count_inc = count_reg + 32'd1;
    assign tag_shift = {in_byte, tag_reg[31:8]};
    assign len_shift = {in_byte, len_reg[31:8]};
    assign word      = {in_byte, low_reg};

    // Parse step for one byte
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        chan_next  = chan_reg;
        low_next   = low_reg;
        n_samples  = 2'd0;
        unique case (phase_reg) inside
            PH_HEADER:
            begin
                tag_next   = tag_shift;
                count_next = count_inc;
                if (count_reg == 32'd3 && tag_shift != TAG_RIFF)
                begin
                    phase_next = PH_BAD;
                end
                else if (count_reg == 32'd11)
                begin
                    if (tag_shift != TAG_WAVE)
                    begin
                        phase_next = PH_BAD;
                    end
                    else
                    begin
                        phase_next = PH_SUBHDR;
                        count_next = '0;
                    end
                end
            end
            PH_SUBHDR:
            begin
                if (count_reg < 32'd4)
                begin
                    tag_next = tag_shift;
                end
                else
                begin
                    len_next = len_shift;
                end
                count_next = count_inc;
                if (count_reg == 32'd7)
                begin
                    count_next = '0;
                    if (tag_reg == TAG_FMT)
                    begin
                        if (len_shift < FMT_MIN_LEN)
                        begin
                            len_next = FMT_MIN_LEN;
                        end
                        phase_next = PH_FMT;
                    end
                    else if (tag_reg == TAG_DATA)
                    begin
                        phase_next = (len_shift == '0) ? PH_NODATA : PH_DATA;
                    end
                    else if (len_shift != '0)
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_FMT, PH_SKIP:
            begin
                if (phase_reg == PH_FMT)
                begin
                    if (count_reg == 32'd2)
                    begin
                        chan_next[7:0] = in_byte;
                    end
                    else if (count_reg == 32'd3)
                    begin
                        chan_next[15:8] = in_byte;
                    end
                end
                count_next = count_inc;
                if (count_inc == len_reg)
                begin
                    phase_next = PH_SUBHDR;
                    count_next = '0;
                end
            end
            PH_DATA:
            begin
                if (!count_reg[0])
                begin
                    low_next = in_byte;
                end
                else
                begin
                    n_samples = (chan_reg == 16'd1) ? 2'd2 : 2'd1;
                end
                count_next = count_inc;
                if (count_inc == len_reg)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE, PH_BAD, PH_NODATA:
            begin
            end
        endcase

        // Phase this byte leads to, before any restart
        phase_after = phase_next;

        // Final byte of the file: report the outcome and start over
        if (in_last)
        begin
            phase_next = PH_HEADER;
            count_next = '0;
            tag_next   = '0;
            len_next   = '0;
            chan_next  = 16'd2;
            low_next   = '0;
        end
    end

    // Terminal status from the phase reached after this byte
    always_comb
    begin
        term_status = ST_NODATA;
        case (phase_after)
            PH_HEADER: term_status = ST_BAD;
            PH_DATA:   term_status = ST_TRUNC;
            PH_DONE:   term_status = ST_DONE;
            PH_BAD:    term_status = ST_BAD;
            default:   term_status = ST_NODATA;
        endcase
    end

    assign pkt.sample    = word;
    assign pkt.n_samples = n_samples;
    assign pkt.term      = in_last;
    assign pkt.status    = term_status;
    assign pkt_push      = take && (n_samples != 2'd0 || in_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            count_reg <= '0;
            tag_reg   <= '0;
            len_reg   <= '0;
            chan_reg  <= 16'd2;
            low_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            chan_reg  <= chan_next;
            low_reg   <= low_next;
        end
    end

endmodule

// ----- design/wrp_fifo.sv -----
`timescale 1ns / 1ps

module wrp_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  wrp_pkg::pkt_t wr_data,
    output logic          full,
    input  logic          pop,
    output wrp_pkg::pkt_t rd_data,
    output logic          empty
);
    import wrp_pkg::*;

    localparam logic [FIFO_PTR_W-1:0] LAST_PTR = FIFO_PTR_W'(FIFO_DEPTH - 1);
    localparam logic [FIFO_CNT_W-1:0] DEPTH_CNT = FIFO_CNT_W'(FIFO_DEPTH);
    localparam logic [FIFO_PTR_W-1:0] PTR_ONE = FIFO_PTR_W'(1);
    localparam logic [FIFO_CNT_W-1:0] CNT_ONE = FIFO_CNT_W'(1);

    pkt_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (cnt_reg == DEPTH_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_ONE;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Packet storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- design/wrp_back.sv -----
`timescale 1ns / 1ps

module wrp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fifo_empty,
    input  wrp_pkg::pkt_t fifo_data,
    output logic          fifo_pop,
    input  logic          pop,
    output logic          empty,
    output logic [15:0]   sample,
    output logic          duplicate,
    output logic [2:0]    status,
    output logic          last
);
    import wrp_pkg::*;

    pkt_t       cur_reg, cur_next;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] total;
    logic       is_sample;
    logic       xfer;
    logic       final_xfer;
    logic       load;

    // Results held by the current packet: samples first, then the status
    assign total      = cur_reg.n_samples + {1'b0, cur_reg.term};
    assign is_sample  = idx_reg < cur_reg.n_samples;
    assign xfer       = valid_reg && pop;
    assign final_xfer = xfer && (idx_reg + 2'd1 == total);
    assign load       = !valid_reg || final_xfer;
    assign fifo_pop   = load && !fifo_empty;

    // Result ports
    assign empty     = !valid_reg;
    assign sample    = is_sample ? cur_reg.sample : 16'd0;
    assign duplicate = is_sample && (idx_reg == 2'd1);
    assign status    = is_sample ? 3'(ST_SAMPLE) : 3'(cur_reg.status);
    assign last      = !is_sample;

    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            cur_next   = fifo_data;
            valid_next = !fifo_empty;
            idx_next   = '0;
        end
        else if (xfer)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

// ----- design/wav_riff_pcm16_stream_parser.sv -----
`timescale 1ns / 1ps

// Byte-serial RIFF/WAVE PCM16 parser. One file byte is taken per cycle whenever
// full is low; the parser handles each byte in the cycle it is taken and queues
// what it produced (up to two samples and, on the byte flagged in_last, one
// terminal status) in a four-packet queue. The result side hands out one result
// per cycle from that queue while pop is high, so a mono data stream sustains
// one byte per cycle (two bytes yield two results) and input stalls only when
// the result side is popped more slowly than results are made. Each result is
// registered into the queue and then into the output stage before it reaches
// the result ports. Samples are Q1.15 with status 0; each stream ends with
// exactly one result with last set carrying done, bad header, no data or
// truncated data, and the parser then starts over on the next byte.
module wav_riff_pcm16_stream_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] sample,
    output logic               duplicate,
    output logic [2:0]         status,
    output logic               last
);
    import wrp_pkg::*;

    pkt_t        front_pkt;
    pkt_t        queue_pkt;
    logic        front_push;
    logic        queue_full;
    logic        queue_empty;
    logic        queue_pop;
    logic [15:0] sample_bits;

    assign full = queue_full;

    wrp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (push && !queue_full),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .pkt_push (front_push),
        .pkt      (front_pkt)
    );

    wrp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .wr_data (front_pkt),
        .full    (queue_full),
        .pop     (queue_pop),
        .rd_data (queue_pkt),
        .empty   (queue_empty)
    );

    wrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (queue_empty),
        .fifo_data  (queue_pkt),
        .fifo_pop   (queue_pop),
        .pop        (pop),
        .empty      (empty),
        .sample     (sample_bits),
        .duplicate  (duplicate),
        .status     (status),
        .last       (last)
    );

    assign sample = $signed(sample_bits);

    // A terminal result never carries sample data
    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (status != 3'(ST_SAMPLE) && sample == 16'sd0))
        else $error("terminal result carries sample status or data");

    // Duplicates are only ever sample results
    a_dup_is_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && duplicate) |-> (status == 3'(ST_SAMPLE) && !last))
        else $error("duplicate flag on a non-sample result");

    // A waiting result is not dropped without a pop
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(last)))
        else $error("pending result changed without a transfer");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import wrp_pkg::*;

    localparam int LIMIT = 300000;
    localparam int PHASE_BYTES = 72;
    localparam int HOLD_CYCLES = 400;
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } file_byte_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               dup;
        status_t            status;
        logic               last;
    } wav_result_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         in_byte = 8'h00;
    logic               in_last = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [15:0] sample;
    logic               duplicate;
    logic [2:0]         status;
    logic               last;

    file_byte_t  pend_q[$];
    wav_result_t wav_results_q[$];
    logic [7:0]  file_bytes[$];

    idle_mode_t idle_mode = IDLE_NONE;
    idle_mode_t phase_modes[5] =
        '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE};
    int hold_left = 0;
    int cycles = 0;
    int n_errors = 0;
    int n_bytes = 0;
    int n_files = 0;
    int n_results = 0;
    int n_dups = 0;
    int n_ends = 0;
    int phase_bytes = 0;

    // Parser mirror state
    phase_t      p_phase;
    logic [31:0] p_cnt;
    logic [31:0] p_tag;
    logic [31:0] p_len;
    logic [15:0] p_chans;
    logic [7:0]  p_lo;

    wav_riff_pcm16_stream_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .empty     (empty),
        .pop       (pop),
        .sample    (sample),
        .duplicate (duplicate),
        .status    (status),
        .last      (last)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, wav_results_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Long result hold-off countdown
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 40)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic clear_parser();
        p_phase = PH_HEADER;
        p_cnt   = '0;
        p_tag   = '0;
        p_len   = '0;
        p_chans = 16'd2;
        p_lo    = '0;
    endtask

    // Queue one predicted result at the tail
    task automatic expect_result(input logic [15:0] s, input logic d,
                                 input status_t st, input logic l);
        wav_result_t r;
        r.sample = s;
        r.dup    = d;
        r.status = st;
        r.last   = l;
        wav_results_q.insert(wav_results_q.size(), r);
    endtask

    // Advance the parser mirror by one byte and queue what it yields
    task automatic parse_byte(input logic [7:0] b, input logic lst);
        logic [31:0] k;
        logic [15:0] s;
        status_t     st;
        k = p_cnt;
        case (p_phase)
            PH_HEADER:
            begin
                p_tag = {b, p_tag[31:8]};
                p_cnt = k + 1;
                if (k == 3 && p_tag != TAG_RIFF)
                    p_phase = PH_BAD;
                else if (k == 11)
                begin
                    if (p_tag != TAG_WAVE)
                        p_phase = PH_BAD;
                    else
                    begin
                        p_phase = PH_SUBHDR;
                        p_cnt   = '0;
                    end
                end
            end
            PH_SUBHDR:
            begin
                if (k < 4)
                    p_tag = {b, p_tag[31:8]};
                else
                    p_len = {b, p_len[31:8]};
                p_cnt = k + 1;
                if (k == 7)
                begin
                    p_cnt = '0;
                    if (p_tag == TAG_FMT)
                    begin
                        if (p_len < FMT_MIN_LEN)
                            p_len = FMT_MIN_LEN;
                        p_phase = PH_FMT;
                    end
                    else if (p_tag == TAG_DATA)
                        p_phase = (p_len == 0) ? PH_NODATA : PH_DATA;
                    else if (p_len != 0)
                        p_phase = PH_SKIP;
                end
            end
            PH_FMT, PH_SKIP:
            begin
                if (p_phase == PH_FMT)
                begin
                    if (k == 2)
                        p_chans[7:0] = b;
                    else if (k == 3)
                        p_chans[15:8] = b;
                end
                p_cnt = k + 1;
                if (p_cnt == p_len)
                begin
                    p_phase = PH_SUBHDR;
                    p_cnt   = '0;
                end
            end
            PH_DATA:
            begin
                if (!k[0])
                    p_lo = b;
                else
                begin
                    s = {b, p_lo};
                    expect_result(s, 1'b0, ST_SAMPLE, 1'b0);
                    if (p_chans == 16'd1)
                        expect_result(s, 1'b1, ST_SAMPLE, 1'b0);
                end
                p_cnt = k + 1;
                if (p_cnt == p_len)
                    p_phase = PH_DONE;
            end
            default: ;
        endcase

        if (lst)
        begin
            case (p_phase)
                PH_HEADER: st = ST_BAD;
                PH_DATA:   st = ST_TRUNC;
                PH_DONE:   st = ST_DONE;
                PH_BAD:    st = ST_BAD;
                default:   st = ST_NODATA;
            endcase
            expect_result(16'd0, 1'b0, st, 1'b1);
            clear_parser();
        end
    endtask

    // Add one byte to the file under construction
    task automatic append_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endtask

    task automatic put_word(input logic [31:0] w);
        append_byte(w[7:0]);
        append_byte(w[15:8]);
        append_byte(w[23:16]);
        append_byte(w[31:24]);
    endtask

    // Move the assembled file into the send queue, flagging its final byte
    task automatic emit_file();
        int unsigned i;
        file_byte_t  fb;
        for (i = 0; i < file_bytes.size(); i++)
        begin
            fb.data = file_bytes[i];
            fb.last = (i == file_bytes.size() - 1);
            pend_q.insert(pend_q.size(), fb);
        end
        phase_bytes += file_bytes.size();
        n_files++;
        file_bytes.delete();
    endtask

    // Mostly well-formed WAV files with random content, some noise and breakage
    task automatic add_random_file();
        int unsigned n_pre;
        int unsigned i;
        int unsigned j;
        int unsigned body;
        int unsigned cut;
        logic [31:0] len;
        logic [15:0] ch;
        logic [7:0]  b;
        logic        ended;
        ended = 1'b0;
        if ($urandom_range(99) < 8)
        begin
            n_pre = $urandom_range(1, 10);
            repeat (n_pre) append_byte(8'($urandom));
        end
        else
        begin
            put_word(($urandom_range(99) < 4) ? TAG_RIFF ^ (32'd1 << $urandom_range(31))
                                              : TAG_RIFF);
            put_word($urandom);
            put_word(($urandom_range(99) < 4) ? TAG_WAVE ^ (32'd1 << $urandom_range(31))
                                              : TAG_WAVE);
            n_pre = $urandom_range(2);
            for (i = 0; i < n_pre && !ended; i++)
            begin
                if ($urandom_range(99) < 60)
                begin
                    // fmt chunk, tiny lengths included
                    len = ($urandom_range(1) == 0) ? 32'($urandom_range(3))
                                                   : 32'($urandom_range(16, 18));
                    case ($urandom_range(7))
                        0, 1, 2: ch = 16'd1;
                        3, 4:    ch = 16'd2;
                        5:       ch = 16'd0;
                        6:       ch = 16'hFFFF;
                        default: ch = 16'($urandom);
                    endcase
                    put_word(TAG_FMT);
                    put_word(len);
                    body = (len < 4) ? 4 : len;
                    for (j = 0; j < body; j++)
                        append_byte((j == 2) ? ch[7:0] :
                                    (j == 3) ? ch[15:8] : 8'($urandom));
                end
                else
                begin
                    // chunk to be skipped
                    case ($urandom_range(9))
                        0, 1:    len = 32'd0;
                        2:       len = 32'hFFFF_FFFF;
                        default: len = 32'($urandom_range(1, 6));
                    endcase
                    put_word(($urandom_range(1) == 0) ? TAG_LIST : 32'($urandom));
                    put_word(len);
                    if (len > 6)
                    begin
                        repeat ($urandom_range(6)) append_byte(8'($urandom));
                        ended = 1'b1;
                    end
                    else
                        repeat (len) append_byte(8'($urandom));
                end
            end
            if (!ended && $urandom_range(9) != 0)
            begin
                case ($urandom_range(19))
                    0:       len = 32'd0;
                    1:       len = 32'hFFFF_FFFF;
                    default: len = 32'($urandom_range(1, 24));
                endcase
                put_word(TAG_DATA);
                put_word(len);
                body = (len > 24) ? $urandom_range(24) : len;
                for (j = 0; j < body; j++)
                begin
                    case ($urandom_range(7))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        2:       b = 8'h80;
                        3:       b = 8'h7F;
                        default: b = 8'($urandom);
                    endcase
                    append_byte(b);
                end
                // bytes after a complete data chunk are ignored
                if (len <= 24 && $urandom_range(3) == 0)
                    repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
            end
        end
        if ($urandom_range(4) == 0)
        begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
        emit_file();
    endtask

    // Byte sender: transfer on push && !full, then load the next pending byte
    always @(posedge clk)
    begin : sender
        file_byte_t nxt;
        logic       gap;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                parse_byte(in_byte, in_last);
                n_bytes++;
            end
            if (!push || !full)
            begin
                gap = (idle_mode == IDLE_SEND && $urandom_range(99) < 65) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(99) < 12);
                if (pend_q.size() != 0 && !gap)
                begin
                    nxt = pend_q.pop_front();
                    push    <= 1'b1;
                    in_byte <= nxt.data;
                    in_last <= nxt.last;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Result checker: compare each transfer against the oldest prediction
    always @(posedge clk)
    begin : result_check
        wav_result_t want;
        logic        stall;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (wav_results_q.size() == 0)
                    report_mismatch($sformatf(
                        "unexpected result sample=%0d dup=%0b status=%0d last=%0b",
                        sample, duplicate, status, last));
                else
                begin
                    want = wav_results_q.pop_front();
                    n_results++;
                    if (sample !== want.sample)
                        report_mismatch($sformatf("sample %0d, expected %0d",
                                                  sample, want.sample));
                    if (duplicate !== want.dup)
                        report_mismatch($sformatf("duplicate %0b, expected %0b",
                                                  duplicate, want.dup));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  last, want.last));
                    if (want.dup)
                        n_dups++;
                    if (want.last)
                        n_ends++;
                end
            end
            stall = (idle_mode == IDLE_RECV && $urandom_range(99) < 65) ||
                    (idle_mode == IDLE_BOTH && $urandom_range(99) < 12);
            pop <= (hold_left == 0) && !stall;
        end
    end

    // Stimulus sequence
    initial
    begin
        clear_parser();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header ends early
        file_bytes = '{8'h52, 8'h49, 8'h46};
        emit_file();
        // Wrong magic: bad header decided on byte four, end flagged a byte later
        put_word(TAG_RIFF ^ 32'h8000_0000);
        append_byte(8'hFF);
        emit_file();
        // Minimal stereo file with the extreme sample values
        put_word(TAG_RIFF);
        put_word(32'd0);
        put_word(TAG_WAVE);
        put_word(TAG_DATA);
        put_word(32'd4);
        put_word(32'h7FFF_8000);
        emit_file();
        while (pend_q.size() != 0 || push)
            @(posedge clk);

        foreach (phase_modes[p])
        begin
            idle_mode   = phase_modes[p];
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
                add_random_file();
            // last phase: results held off while the sender keeps pushing
            if (p == 4)
                hold_left <= HOLD_CYCLES;
            while (pend_q.size() != 0 || push)
                @(posedge clk);
        end

        idle_mode = IDLE_NONE;
        while (wav_results_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (wav_results_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", wav_results_q.size()));

        $display("Parsed %0d bytes in %0d files; checked %0d results (%0d mono copies, %0d ends).",
                 n_bytes, n_files, n_results, n_dups, n_ends);
        $display("Phases: free running, sender gaps, result stalls, both, long result hold-off.");
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
